### hw/rtl/dmi_pkg.sv
// Shared types and constants for the directional movement index block.
`default_nettype none
package dmi_pkg;

  localparam int unsigned PriceW    = 32;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned SeenW     = 10;
  localparam int unsigned SumW      = 48;
  localparam int unsigned ValW      = 23;
  localparam int unsigned TotW      = 32;
  localparam int unsigned NumW      = 72;
  localparam int unsigned CntW      = 7;
  localparam logic [7:0]  PeriodRst = 8'd14;
  localparam logic [ValW-1:0] FullScale = 23'd6553600;
  localparam logic [SeenW-1:0] SeenMax = 10'd1023;
  localparam int unsigned FifoDepth = 2;

  // One classified bar handed from the front end to the back end.
  typedef struct packed {
    logic [PriceW-1:0] tr;
    logic [PriceW-1:0] pdm;
    logic [PriceW-1:0] mdm;
    logic [SeenW-1:0]  n;
    logic              first;
    logic [TimeW-1:0]  stamp;
  } bar_ent_t;

  // Request to the serial divider: remainder seed, bits to shift in, step count.
  typedef struct packed {
    logic              start;
    logic [SumW-1:0]   rem0;
    logic [NumW-1:0]   num;
    logic [CntW-1:0]   cnt;
    logic [SumW-1:0]   den;
  } div_req_t;

endpackage
`default_nettype wire

### hw/rtl/dmi_front.sv
// Front end: keeps the previous bar and forms true range and directional moves.
`default_nettype none
module dmi_front (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           acc,
  input  wire [dmi_pkg::PriceW-1:0]     high,
  input  wire [dmi_pkg::PriceW-1:0]     low,
  input  wire [dmi_pkg::PriceW-1:0]     close,
  input  wire [dmi_pkg::TimeW-1:0]      stamp,
  input  wire                           start,
  output dmi_pkg::bar_ent_t             ent
);
  logic [dmi_pkg::PriceW-1:0] last_high_r, last_low_r, last_close_r;
  logic [dmi_pkg::SeenW-1:0]  seen_r, seen_nxt, n;
  logic signed [dmi_pkg::PriceW:0] hl, hc, lc, up, dn, trs;

  always_comb begin
    n   = start ? '0 : seen_r;
    hl  = $signed({1'b0, high}) - $signed({1'b0, low});
    hc  = $signed({1'b0, high}) - $signed({1'b0, last_close_r});
    lc  = $signed({1'b0, low}) - $signed({1'b0, last_close_r});
    if (hc < 0) hc = -hc;
    if (lc < 0) lc = -lc;
    trs = hl;
    if (hc > trs) trs = hc;
    if (lc > trs) trs = lc;
    up  = $signed({1'b0, high}) - $signed({1'b0, last_high_r});
    dn  = $signed({1'b0, last_low_r}) - $signed({1'b0, low});
    ent.tr    = trs[dmi_pkg::PriceW-1:0];
    ent.pdm   = (up > dn && up > 0) ? up[dmi_pkg::PriceW-1:0] : '0;
    ent.mdm   = (dn > up && dn > 0) ? dn[dmi_pkg::PriceW-1:0] : '0;
    ent.n     = n;
    ent.first = (n == '0);
    ent.stamp = stamp;
    if (n == '0) seen_nxt = 10'd1;
    else if (n == dmi_pkg::SeenMax) seen_nxt = n;
    else seen_nxt = n + 10'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      last_high_r <= '0;
      last_low_r <= '0;
      last_close_r <= '0;
    end else if (acc) begin
      seen_r <= seen_nxt;
      last_high_r <= high;
      last_low_r <= low;
      last_close_r <= close;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/dmi_fifo.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module dmi_fifo (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  dmi_pkg::bar_ent_t wdata,
  input  wire               pop,
  output dmi_pkg::bar_ent_t rdata,
  output logic              full,
  output logic              empty
);
  dmi_pkg::bar_ent_t mem_r [dmi_pkg::FifoDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/dmi_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module dmi_div (
  input  wire                         clk,
  input  wire                         rst_n,
  input  dmi_pkg::div_req_t           req,
  output logic                        busy,
  output logic                        done,
  output logic [dmi_pkg::SumW-1:0]    quo
);
  logic [dmi_pkg::SumW-1:0] rem_r, quo_r;
  logic [dmi_pkg::NumW-1:0] num_r;
  logic [dmi_pkg::SumW-1:0] den_r;
  logic [dmi_pkg::CntW-1:0] cnt_r;
  logic                     busy_r, done_r;
  logic [dmi_pkg::SumW:0]   t, d;

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    t = {rem_r, num_r[dmi_pkg::NumW-1]};
    d = t - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem0;
      num_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[dmi_pkg::NumW-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        rem_r <= d[dmi_pkg::SumW-1:0];
        quo_r <= {quo_r[dmi_pkg::SumW-2:0], 1'b1};
      end else begin
        rem_r <= t[dmi_pkg::SumW-1:0];
        quo_r <= {quo_r[dmi_pkg::SumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= req.cnt;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/dmi_back.sv
// Back end: smoothing, DI, DX and ADX sequencer around the shared divider.
`default_nettype none
module dmi_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [7:0]                   period,
  input  wire                          empty,
  input  dmi_pkg::bar_ent_t            ent,
  output logic                         pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [dmi_pkg::ValW-1:0]     adx,
  output logic [dmi_pkg::ValW-1:0]     pdi,
  output logic [dmi_pkg::ValW-1:0]     mdi,
  output logic [dmi_pkg::TimeW-1:0]    stamp,
  output logic                         div_start
);
  localparam logic [3:0] S_IDLE = 4'd0, S_UPD = 4'd1, S_SM = 4'd2, S_CHK = 4'd3,
                         S_DI = 4'd4, S_DX = 4'd5, S_ACC = 4'd6, S_ADX = 4'd7,
                         S_OUT = 4'd8;

  logic [3:0] st_r, st_nxt;
  dmi_pkg::bar_ent_t ent_r;
  logic [dmi_pkg::SumW-1:0] rs_r, us_r, ds_r;
  logic [dmi_pkg::TotW-1:0] dxt_r, mul_r;
  logic [dmi_pkg::ValW-1:0] adx_r, pdi_r, mdi_r, dx_r;
  logic [1:0] idx_r;
  logic go_r;
  logic out_valid_r;
  logic [dmi_pkg::ValW-1:0] oadx_r, opdi_r, omdi_r;
  logic [dmi_pkg::TimeW-1:0] ostamp_r;

  logic [7:0] p;
  logic [9:0] p2m1;
  dmi_pkg::div_req_t req;
  logic div_busy, div_done;
  logic [dmi_pkg::SumW-1:0] q;
  logic [dmi_pkg::SumW-1:0] ra, rb, ssel, snew;
  logic [dmi_pkg::SumW+4:0] a25;
  logic [dmi_pkg::SumW-1:0] trs, news;
  logic rzero, rfull;
  logic [dmi_pkg::ValW:0] dsum;
  logic [dmi_pkg::ValW-1:0] ddiff;
  logic [dmi_pkg::TotW-1:0] dxt_sum, prod;

  dmi_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .busy (div_busy),
    .done (div_done),
    .quo  (q)
  );

  assign out_valid = out_valid_r;
  assign adx = oadx_r;
  assign pdi = opdi_r;
  assign mdi = omdi_r;
  assign stamp = ostamp_r;
  assign pop = (st_r == S_IDLE) && !empty;
  assign div_start = req.start;

  always_comb begin
    p     = (period == 8'd0) ? 8'd1 : period;
    p2m1  = {1'b0, p, 1'b0} - 10'd1;
    dsum  = {1'b0, pdi_r} + {1'b0, mdi_r};
    ddiff = (pdi_r > mdi_r) ? pdi_r - mdi_r : mdi_r - pdi_r;
    dxt_sum = dxt_r + {9'd0, dx_r};
    prod  = {9'd0, adx_r} * {24'd0, p - 8'd1};
    // Operands of the ratio unit: DI in one state, DX in the other.
    if (st_r == S_DX) begin
      ra = {{(dmi_pkg::SumW-dmi_pkg::ValW){1'b0}}, ddiff};
      rb = {{(dmi_pkg::SumW-dmi_pkg::ValW-1){1'b0}}, dsum};
    end else begin
      ra = idx_r[0] ? ds_r : us_r;
      rb = rs_r;
    end
    rzero = (rb == '0);
    rfull = (ra >= rb);
    // a * 6553600 is (a * 25) << 18.
    a25 = {1'b0, ra, 4'd0} + {2'd0, ra, 3'd0} + {5'd0, ra};
    case (idx_r)
      2'd0: begin ssel = rs_r; trs = {16'd0, ent_r.tr}; end
      2'd1: begin ssel = us_r; trs = {16'd0, ent_r.pdm}; end
      default: begin ssel = ds_r; trs = {16'd0, ent_r.mdm}; end
    endcase
    news = {trs[dmi_pkg::SumW-9:0], 8'd0};
    snew = ssel - q + news;
    req = '0;
    if (!go_r) begin
      case (st_r)
        S_SM: begin
          req.start = 1'b1;
          req.num   = {ssel, 24'd0};
          req.cnt   = 7'd48;
          req.den   = {40'd0, p};
        end
        S_DI, S_DX: begin
          req.start = !rzero && !rfull;
          req.rem0  = a25[dmi_pkg::SumW+4:5];
          req.num   = {a25[4:0], 67'd0};
          req.cnt   = 7'd23;
          req.den   = rb;
        end
        S_ADX: begin
          req.start = 1'b1;
          req.num   = {mul_r, 40'd0};
          req.cnt   = 7'd32;
          req.den   = {40'd0, p};
        end
        default: req = '0;
      endcase
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (!empty) st_nxt = S_UPD;
      S_UPD: begin
        if (ent_r.first) st_nxt = S_IDLE;
        else if (ent_r.n <= {2'd0, p}) st_nxt = S_CHK;
        else st_nxt = S_SM;
      end
      S_SM: if (go_r && div_done && idx_r == 2'd2) st_nxt = S_CHK;
      S_CHK: st_nxt = (ent_r.n < {2'd0, p}) ? S_IDLE : S_DI;
      S_DI: if ((!go_r && (rzero || rfull)) || (go_r && div_done)) begin
        if (idx_r[0]) st_nxt = S_DX;
      end
      S_DX: if ((!go_r && (rzero || rfull)) || (go_r && div_done)) st_nxt = S_ACC;
      S_ACC: begin
        if (ent_r.n < p2m1) st_nxt = S_IDLE;
        else st_nxt = S_ADX;
      end
      S_ADX: if (go_r && div_done) st_nxt = S_OUT;
      S_OUT: if (!out_valid_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      go_r <= 1'b0;
      idx_r <= '0;
      out_valid_r <= 1'b0;
      rs_r <= '0;
      us_r <= '0;
      ds_r <= '0;
      dxt_r <= '0;
      adx_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (req.start) go_r <= 1'b1;
      else if (div_done) go_r <= 1'b0;
      if (st_r == S_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (!empty) ent_r <= ent;
        S_UPD: begin
          idx_r <= '0;
          if (ent_r.first) begin
            rs_r <= '0;
            us_r <= '0;
            ds_r <= '0;
            dxt_r <= '0;
            adx_r <= '0;
          end else if (ent_r.n <= {2'd0, p}) begin
            rs_r <= rs_r + {8'd0, ent_r.tr, 8'd0};
            us_r <= us_r + {8'd0, ent_r.pdm, 8'd0};
            ds_r <= ds_r + {8'd0, ent_r.mdm, 8'd0};
          end
        end
        S_SM: if (go_r && div_done) begin
          case (idx_r)
            2'd0: rs_r <= snew;
            2'd1: us_r <= snew;
            default: ds_r <= snew;
          endcase
          idx_r <= (idx_r == 2'd2) ? 2'd0 : idx_r + 2'd1;
        end
        S_DI: if ((!go_r && (rzero || rfull)) || (go_r && div_done)) begin
          if (idx_r[0]) mdi_r <= rzero ? '0 : (rfull ? dmi_pkg::FullScale : q[22:0]);
          else pdi_r <= rzero ? '0 : (rfull ? dmi_pkg::FullScale : q[22:0]);
          idx_r <= idx_r[0] ? 2'd0 : 2'd1;
        end
        S_DX: if ((!go_r && (rzero || rfull)) || (go_r && div_done)) begin
          dx_r <= rzero ? '0 : (rfull ? dmi_pkg::FullScale : q[22:0]);
        end
        S_ACC: begin
          if (ent_r.n <= p2m1) begin
            dxt_r <= dxt_sum;
            mul_r <= dxt_sum;
          end else begin
            mul_r <= prod + {9'd0, dx_r};
          end
        end
        S_ADX: if (go_r && div_done) begin
          adx_r <= (q > {25'd0, dmi_pkg::FullScale}) ? dmi_pkg::FullScale : q[22:0];
        end
        S_OUT: if (!out_valid_r || out_ready) begin
          oadx_r <= adx_r;
          opdi_r <= pdi_r;
          omdi_r <= mdi_r;
          ostamp_r <= ent_r.stamp;
        end
        default: ;
      endcase
    end
  end

  // Divider start only when idle; catches a sequencer that relaunches too early.
  always_ff @(posedge clk) begin
    if (rst_n && req.start && div_busy) $error("divider restarted while busy");
  end
endmodule
`default_nettype wire

### hw/rtl/directional_movement_index_top.sv
// Top level of the Wilder average directional index (ADX) block.
`default_nettype none
// Each request carries one price bar. A front end classifies the bar against the
// previous one (true range, +DM, -DM) and places it in a two-entry queue, so new
// bars are taken while the back end still works. The back end runs every division
// on one shared restoring divider that produces one quotient bit per cycle: three
// 48-step smoothing divisions, three 23-step ratio divisions (+DI, -DI, DX) and one
// 32-step ADX division. In steady state that divider sets the pace of a bar from pop
// to pop, plus any wait for the output register to be taken; warm-up bars need
// fewer divisions. A result request appears from bar 2*period-1 of a series on,
// counting its first bar as bar 0, and sits in an output register until taken.
// Smoothed sums keep 8 fraction bits; DI and ADX are unsigned Q7.16. Write the
// period only while the block is idle.
module directional_movement_index_top (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_wr_en,
  input  wire  [7:0]   cfg_wr_data,   // period
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [159:0] in_tdata,      // bar_high, bar_low, bar_close, bar_time
  input  wire          in_tuser,      // series_start
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [135:0] out_tdata      // adx_value, plus_di_value, minus_di_value, out_time
);
  logic [7:0] period_r;
  logic acc, full, empty, pop, div_start;
  dmi_pkg::bar_ent_t fent, bent;
  logic [dmi_pkg::ValW-1:0] adx, pdi, mdi;
  logic [dmi_pkg::TimeW-1:0] stamp;

  always_ff @(posedge clk) begin
    if (!rst_n) period_r <= dmi_pkg::PeriodRst;
    else if (cfg_wr_en) period_r <= cfg_wr_data;
  end

  assign in_tready = !full;
  assign acc = in_tvalid && in_tready;

  dmi_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (acc),
    .high (in_tdata[31:0]),
    .low  (in_tdata[63:32]),
    .close(in_tdata[95:64]),
    .stamp(in_tdata[159:96]),
    .start(in_tuser),
    .ent  (fent)
  );

  dmi_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (acc),
    .wdata(fent),
    .pop  (pop),
    .rdata(bent),
    .full (full),
    .empty(empty)
  );

  dmi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .period   (period_r),
    .empty    (empty),
    .ent      (bent),
    .pop      (pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .adx      (adx),
    .pdi      (pdi),
    .mdi      (mdi),
    .stamp    (stamp),
    .div_start(div_start)
  );

  assign out_tdata = {3'd0, stamp, mdi, pdi, adx};

  // Results never exceed full scale.
  a_adx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22:0] <= dmi_pkg::FullScale))
    else $error("adx above full scale");
  a_di_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[45:23] <= dmi_pkg::FullScale &&
                    out_tdata[68:46] <= dmi_pkg::FullScale))
    else $error("DI above full scale");
  // The queue is never popped while empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
  // A divider launch never coincides with a bar being popped.
  a_start_pop: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !pop)
    else $error("divider launched while idle");
endmodule
`default_nettype wire

### tb/directional_movement_index_top_tb.sv
// Self-checking testbench for the directional movement index (ADX) top level.
`timescale 1ns / 100ps
`default_nettype none
module directional_movement_index_top_tb;

  // One expected or observed result request, in the order of the output fields.
  typedef struct packed {
    logic [dmi_pkg::ValW-1:0]  adx;
    logic [dmi_pkg::ValW-1:0]  pdi;
    logic [dmi_pkg::ValW-1:0]  mdi;
    logic [dmi_pkg::TimeW-1:0] stamp;
  } adx_res_t;

  // A directed bar. Where is_typed is set, the expected result is written out.
  typedef struct {
    logic [31:0]              high;
    logic [31:0]              low;
    logic [31:0]              close;
    bit                       start;
    bit                       is_typed;
    logic [dmi_pkg::ValW-1:0] e_adx;
    logic [dmi_pkg::ValW-1:0] e_pdi;
    logic [dmi_pkg::ValW-1:0] e_mdi;
  } bar_row_t;

  localparam longint unsigned Full = 64'd6553600;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [159:0] in_tdata;   // bar_high, bar_low, bar_close, bar_time
  logic in_tuser;           // series_start
  logic out_tvalid;
  logic out_tready;
  logic [135:0] out_tdata;  // adx_value, plus_di_value, minus_di_value, out_time

  directional_movement_index_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Predictor state: a private copy of the period and the series state.
  logic [7:0]      per_reg;
  logic [31:0]     prev_high, prev_low, prev_close;
  longint unsigned seen_cnt;
  longint unsigned tr_sum, up_sum, dn_sum, dx_sum, adx_now;

  adx_res_t adx_expect_q[$];
  int unsigned mismatch_cnt;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned hold_req_cnt, hold_ack_cnt;
  int unsigned hold_left;
  logic [31:0] walk_px;

  // The clock runs with an 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A generous fixed limit. A hung handshake lands here and fails the run.
  initial begin
    #400_000_000;
    $display("directional_movement_index_top_tb NOT OK");
    $finish;
  end

  // floor(a * 100.0 / b) in Q7.16, saturated at full scale, zero for a zero divisor.
  function automatic longint unsigned adx_ratio(longint unsigned a, longint unsigned b);
    logic [127:0] q;
    if (b == 0) return 0;
    if (a >= b) return Full;
    q = ({64'd0, a} * 128'd6553600) / {64'd0, b};
    return (q > Full) ? Full : q[63:0];
  endfunction

  // Advances the predicted state by one accepted bar and tells whether it gives a result.
  task automatic advance_adx(input logic [31:0] hi, input logic [31:0] lo,
                             input logic [31:0] cl, input bit st,
                             input logic [63:0] ts, output bit got, output adx_res_t r);
    longint unsigned p, n, tr, pdm, mdm, pdi, mdi, dsum, ddiff, dx, adx;
    longint hl, hc, lc, up, dn;
    p = (per_reg == 0) ? 1 : per_reg;
    n = st ? 0 : seen_cnt;
    got = 1'b0;
    r = '0;
    if (n == 0) begin
      tr_sum = 0; up_sum = 0; dn_sum = 0; dx_sum = 0; adx_now = 0;
      prev_high = hi; prev_low = lo; prev_close = cl;
      seen_cnt = 1;
      return;
    end
    hl = longint'({32'd0, hi}) - longint'({32'd0, lo});
    hc = longint'({32'd0, hi}) - longint'({32'd0, prev_close});
    lc = longint'({32'd0, lo}) - longint'({32'd0, prev_close});
    if (hc < 0) hc = -hc;
    if (lc < 0) lc = -lc;
    if (hc > hl) hl = hc;
    if (lc > hl) hl = lc;
    tr = hl;
    up = longint'({32'd0, hi}) - longint'({32'd0, prev_high});
    dn = longint'({32'd0, prev_low}) - longint'({32'd0, lo});
    pdm = (up > dn && up > 0) ? up : 0;
    mdm = (dn > up && dn > 0) ? dn : 0;
    if (n <= p) begin
      tr_sum += tr << 8;
      up_sum += pdm << 8;
      dn_sum += mdm << 8;
    end else begin
      tr_sum = tr_sum - tr_sum / p + (tr << 8);
      up_sum = up_sum - up_sum / p + (pdm << 8);
      dn_sum = dn_sum - dn_sum / p + (mdm << 8);
    end
    prev_high = hi; prev_low = lo; prev_close = cl;
    seen_cnt = (n + 1 > 1023) ? 1023 : n + 1;
    if (n < p) return;
    pdi = adx_ratio(up_sum, tr_sum);
    mdi = adx_ratio(dn_sum, tr_sum);
    dsum = pdi + mdi;
    ddiff = (pdi > mdi) ? pdi - mdi : mdi - pdi;
    dx = adx_ratio(ddiff, dsum);
    if (n <= 2 * p - 1) begin
      dx_sum = (dx_sum + dx) & 64'hFFFF_FFFF;
      if (n < 2 * p - 1) return;
      adx = dx_sum / p;
    end else begin
      adx = (adx_now * (p - 1) + dx) / p;
    end
    if (adx > Full) adx = Full;
    adx_now = adx;
    got = 1'b1;
    r.adx = adx[dmi_pkg::ValW-1:0];
    r.pdi = pdi[dmi_pkg::ValW-1:0];
    r.mdi = mdi[dmi_pkg::ValW-1:0];
    r.stamp = ts;
  endtask

  // Writes the period register. It is called only while the block is idle.
  task automatic write_period(input logic [7:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    per_reg = v;
  endtask

  // Offers one bar, after a random gap, and waits for the handshake. On acceptance
  // the predictor is advanced and any expected result is queued. A typed row
  // replaces the predicted values with the ones written in the table.
  task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo, input logic [31:0] cl,
                          input bit st, input bit is_typed, input adx_res_t typed_res);
    logic [63:0] ts;
    bit got;
    adx_res_t r;
    ts = {$urandom, $urandom};
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ts, cl, lo, hi};
    in_tuser <= st;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    advance_adx(hi, lo, cl, st, ts, got, r);
    if (is_typed) begin
      r = typed_res;
      r.stamp = ts;
      got = 1'b1;
    end
    if (got) adx_expect_q = {adx_expect_q, r};
  endtask

  // Stops offering bars and lets the block drain before the next register write.
  // Up to three bars that give no result may still be in flight.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (adx_expect_q.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  // Random bar: mostly a price walk around the last close, sometimes raw noise
  // that covers every bit of the prices and gives highs below lows.
  task automatic send_random_bar(input bit st);
    logic [31:0] hi, lo, cl;
    if ($urandom_range(99) < 25) begin
      hi = $urandom; lo = $urandom; cl = $urandom;
    end else begin
      walk_px = walk_px + $urandom_range(2000) - 1000;
      hi = walk_px + $urandom_range(800);
      lo = walk_px - $urandom_range(800);
      cl = lo + $urandom_range(hi - lo);
    end
    send_bar(hi, lo, cl, st, 1'b0, '0);
  endtask

  // Receiver: random backpressure, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= 3000;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted result request is compared with the oldest expectation.
  always @(posedge clk) begin
    adx_res_t got_res, exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      got_res = {out_tdata[22:0], out_tdata[45:23], out_tdata[68:46], out_tdata[132:69]};
      if (adx_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected result: adx=%0d +di=%0d -di=%0d time=%h",
                   got_res.adx, got_res.pdi, got_res.mdi, got_res.stamp);
      end else begin
        exp_res = adx_expect_q.pop_front();
        if (got_res !== exp_res) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("Mismatch: exp adx=%0d +di=%0d -di=%0d time=%h,",
                     exp_res.adx, exp_res.pdi, exp_res.mdi, exp_res.stamp,
                     " got adx=%0d +di=%0d -di=%0d time=%h",
                     got_res.adx, got_res.pdi, got_res.mdi, got_res.stamp);
        end
      end
    end
  end

  // Directed bars, all at a period of one so that every bar after the first of a
  // series gives a result. Rows with a written expectation are the ones whose answer
  // is plain: a pure up move, no move at all, a pure down move, a zero range and an
  // up move equal to the down move.
  bar_row_t dir_rows[13];

  initial begin
    int unsigned pers[8];
    int unsigned cnts[8];
    dir_rows[0]  = '{32'd100, 32'd100, 32'd100, 1'b1, 1'b0, 23'd0, 23'd0, 23'd0};
    dir_rows[1]  = '{32'd200, 32'd100, 32'd150, 1'b0, 1'b1,
                     23'd6553600, 23'd6553600, 23'd0};
    dir_rows[2]  = '{32'd200, 32'd100, 32'd150, 1'b0, 1'b1, 23'd0, 23'd0, 23'd0};
    dir_rows[3]  = '{32'd150, 32'd50, 32'd100, 1'b0, 1'b1,
                     23'd6553600, 23'd0, 23'd3276800};
    dir_rows[4]  = '{32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 23'd0, 23'd0, 23'd0};
    dir_rows[5]  = '{32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 23'd0, 23'd0, 23'd0};
    dir_rows[6]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0,
                     23'd0, 23'd0, 23'd0};
    dir_rows[7]  = '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 23'd0, 23'd0, 23'd0};
    dir_rows[8]  = '{32'd10, 32'd10, 32'd10, 1'b1, 1'b0, 23'd0, 23'd0, 23'd0};
    dir_rows[9]  = '{32'd10, 32'd10, 32'd10, 1'b0, 1'b1, 23'd0, 23'd0, 23'd0};
    dir_rows[10] = '{32'd30, 32'd5, 32'd20, 1'b0, 1'b0, 23'd0, 23'd0, 23'd0};
    dir_rows[11] = '{32'd25, 32'd8, 32'd12, 1'b0, 1'b0, 23'd0, 23'd0, 23'd0};
    dir_rows[12] = '{32'd33, 32'd0, 32'd20, 1'b0, 1'b1, 23'd0, 23'd0, 23'd0};
    // Random phases: small periods, the largest, and a zero period that acts as one.
    pers = '{14, 2, 255, 0, 5, 1, 3, 8};
    cnts = '{130, 130, 520, 130, 130, 130, 130, 130};

    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 8'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    mismatch_cnt = 0;
    hold_req_cnt = 0;
    hold_ack_cnt = 0;
    hold_left = 0;
    send_idle_pct = 19;
    recv_idle_pct = 51;
    walk_px = 32'd1_000_000;
    per_reg = dmi_pkg::PeriodRst;
    prev_high = '0; prev_low = '0; prev_close = '0;
    seen_cnt = 0;
    tr_sum = 0; up_sum = 0; dn_sum = 0; dx_sum = 0; adx_now = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_period(8'd1);
    foreach (dir_rows[i])
      send_bar(dir_rows[i].high, dir_rows[i].low, dir_rows[i].close, dir_rows[i].start,
               dir_rows[i].is_typed,
               '{dir_rows[i].e_adx, dir_rows[i].e_pdi, dir_rows[i].e_mdi, 64'd0});
    drain_block();

    for (int ph = 0; ph < 8; ph++) begin
      // Three idling patterns in turn: sender light and receiver heavy, the
      // reverse, and no idling at all.
      case (ph % 3)
        0: begin send_idle_pct = 19; recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_period(pers[ph][7:0]);
      // At a period of one every bar gives a result, so a long receiver hold-off
      // fills the output register and the queue and then stalls the input.
      if (pers[ph] == 1) hold_req_cnt++;
      for (int k = 0; k < cnts[ph]; k++)
        send_random_bar((k == 0) ? $urandom_range(1) : (pers[ph] != 255 &&
                                                        $urandom_range(59) == 0));
      drain_block();
    end

    if (mismatch_cnt == 0 && adx_expect_q.size() == 0) begin
      $display("directional_movement_index_top_tb OK");
    end else begin
      $display("directional_movement_index_top_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
